FILE: src/sesc_pkg.sv
package sesc_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
      logic       last_of_string;
      logic       was_escaped;
   } rsp_type;

   localparam int unsigned MAX_SEQ  = 4;
   localparam int unsigned IDX_BITS = $clog2(MAX_SEQ);

   // escaped form of one input byte, ready for serializing
   typedef struct packed {
      logic [MAX_SEQ-1:0][7:0] seq_bytes;
      logic [IDX_BITS-1:0]     last_idx;
      logic                    eos;
      logic                    esc;
   } seq_type;

   typedef enum logic [1:0] {
      KIND_COPY   = 2'd0,
      KIND_LETTER = 2'd1,
      KIND_OCTAL  = 2'd2
   } kind_type;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_A         = 8'h61;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_V         = 8'h76;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_R         = 8'h72;

   localparam logic [7:0] CODE_BEL = 8'd7;
   localparam logic [7:0] CODE_BS  = 8'd8;
   localparam logic [7:0] CODE_TAB = 8'd9;
   localparam logic [7:0] CODE_LF  = 8'd10;
   localparam logic [7:0] CODE_VT  = 8'd11;
   localparam logic [7:0] CODE_FF  = 8'd12;
   localparam logic [7:0] CODE_CR  = 8'd13;

   localparam logic [7:0] PRINT_LO  = 8'h20;
   localparam logic [7:0] PRINT_HI  = 8'h7E;
   localparam logic [7:0] HIGH_BASE = 8'h80;

endpackage

FILE: src/sesc_serializer.sv
module sesc_serializer import sesc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  seq_type in_seq,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                hold_valid_ff, hold_valid_in;
   seq_type             hold_ff, hold_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, out_in;

   logic out_free;
   logic emit;
   logic at_last;

   assign out_free = !out_valid_ff || rsp_ready;
   assign at_last  = (idx_ff == hold_ff.last_idx);
   assign emit     = hold_valid_ff && out_free;
   // a new transaction may load while the final byte of the current one leaves
   assign in_ready = !hold_valid_ff || (emit && at_last);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      if (out_free) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in          = 1'b1;
         out_in.out_byte       = hold_ff.seq_bytes[idx_ff];
         out_in.last_of_item   = at_last;
         out_in.last_of_string = at_last && hold_ff.eos;
         out_in.was_escaped    = hold_ff.esc;
         idx_in                = idx_ff + 1'b1;
         if (at_last) begin
            hold_valid_in = 1'b0;
         end
      end
      if (in_valid && in_ready) begin
         hold_valid_in = 1'b1;
         hold_in       = in_seq;
         idx_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: src/string_escape_encoder_top.sv
// channel   direction  handshake           payload
// req       in         req_valid/req_ready req_data   (in_byte, end_of_string)
// rsp       out        rsp_valid/rsp_ready rsp_data   (out_byte, flags)
// csr       in         csr_we              csr_wdata  (high_bits_printable)
//
// four register stages: input, classify, sequence build, serializer with output register
// a byte yields 1 to 4 output bytes (copied 1, letter escape 2, octal 2 to 4), sent by the
// serializer, one byte per cycle unless rsp stalls; rsp_valid is registered at the output
// synchronous active-high reset clears valid bits and the csr register
// stalls on rsp back up stage by stage; no transaction is dropped or repeated
module string_escape_encoder_top import sesc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_wdata
);

   logic cfg_ff, cfg_in;

   // stage 1: input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff, s1_req_in;
   logic    s1_ready;

   // stage 2: classified byte
   logic       s2_valid_ff, s2_valid_in;
   logic [7:0] s2_byte_ff, s2_byte_in;
   logic       s2_eos_ff, s2_eos_in;
   kind_type   s2_kind_ff, s2_kind_in;
   logic [7:0] s2_letter_ff, s2_letter_in;
   logic       s2_ready;

   logic    s3_ready;
   seq_type s2_seq;

   logic [7:0] letter;
   logic       printable;

   assign cfg_in = csr_we ? csr_wdata : cfg_ff;

   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (s1_ready) begin
         s1_valid_in = req_valid;
         s1_req_in   = req_data;
      end
   end

   // classify
   always_comb begin
      case (s1_req_ff.in_byte)
         CHAR_QUOTE:     letter = CHAR_QUOTE;
         CHAR_BACKSLASH: letter = CHAR_BACKSLASH;
         CODE_LF:        letter = CHAR_N;
         CODE_TAB:       letter = CHAR_T;
         CODE_BEL:       letter = CHAR_A;
         CODE_BS:        letter = CHAR_B;
         CODE_VT:        letter = CHAR_V;
         CODE_FF:        letter = CHAR_F;
         CODE_CR:        letter = CHAR_R;
         default:        letter = 8'd0;
      endcase
      printable = ((s1_req_ff.in_byte >= PRINT_LO) && (s1_req_ff.in_byte <= PRINT_HI))
                  || ((s1_req_ff.in_byte >= HIGH_BASE) && cfg_ff);
   end

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_byte_in   = s2_byte_ff;
      s2_eos_in    = s2_eos_ff;
      s2_kind_in   = s2_kind_ff;
      s2_letter_in = s2_letter_ff;
      if (s2_ready) begin
         s2_valid_in  = s1_valid_ff;
         s2_byte_in   = s1_req_ff.in_byte;
         s2_eos_in    = s1_req_ff.end_of_string;
         s2_letter_in = letter;
         if (letter != 8'd0) begin
            s2_kind_in = KIND_LETTER;
         end else if (printable) begin
            s2_kind_in = KIND_COPY;
         end else begin
            s2_kind_in = KIND_OCTAL;
         end
      end
   end

   // sequence build
   always_comb begin
      logic [7:0] d2, d1, d0;
      d2 = CHAR_ZERO | {6'd0, s2_byte_ff[7:6]};
      d1 = CHAR_ZERO | {5'd0, s2_byte_ff[5:3]};
      d0 = CHAR_ZERO | {5'd0, s2_byte_ff[2:0]};
      s2_seq           = '0;
      s2_seq.eos       = s2_eos_ff;
      s2_seq.esc       = 1'b1;
      s2_seq.seq_bytes[0] = CHAR_BACKSLASH;
      case (s2_kind_ff)
         KIND_COPY: begin
            s2_seq.seq_bytes[0] = s2_byte_ff;
            s2_seq.last_idx     = IDX_BITS'(0);
            s2_seq.esc          = 1'b0;
         end
         KIND_LETTER: begin
            s2_seq.seq_bytes[1] = s2_letter_ff;
            s2_seq.last_idx     = IDX_BITS'(1);
         end
         KIND_OCTAL: begin
            if (s2_byte_ff[7:6] != 2'd0) begin
               s2_seq.seq_bytes[1] = d2;
               s2_seq.seq_bytes[2] = d1;
               s2_seq.seq_bytes[3] = d0;
               s2_seq.last_idx     = IDX_BITS'(3);
            end else if (s2_byte_ff[5:3] != 3'd0) begin
               s2_seq.seq_bytes[1] = d1;
               s2_seq.seq_bytes[2] = d0;
               s2_seq.last_idx     = IDX_BITS'(2);
            end else begin
               s2_seq.seq_bytes[1] = d0;
               s2_seq.last_idx     = IDX_BITS'(1);
            end
         end
         default: begin
            s2_seq.last_idx = IDX_BITS'(0);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff    <= s1_req_in;
      s2_byte_ff   <= s2_byte_in;
      s2_eos_ff    <= s2_eos_in;
      s2_kind_ff   <= s2_kind_in;
      s2_letter_ff <= s2_letter_in;
   end

   sesc_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (s3_ready),
      .in_seq    (s2_seq),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_eos_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_string |-> rsp_data.last_of_item)
      else $error("last_of_string without last_of_item");

   a_copy_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.was_escaped |-> rsp_data.last_of_item)
      else $error("copied byte produced more than one result");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_ready |=> s2_valid_ff && $stable(s2_byte_ff))
      else $error("stage 2 transaction lost under stall");
`endif

endmodule
